/* sv/hnm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_pkg - shared types and constants of the heightmap mesh builder
// Register indexes, field widths and the vertex job passed front to back.
// ----------------------------------------------------------------------------
package hnm_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;

  localparam int HEIGHT_W    = 16;
  localparam int NORM_W      = 18;
  localparam int IDX_W       = 16;
  localparam int COORD_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_MODE   = CFG_IDX_W'(2);

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // one vertex with its neighbourhood, ready for the arithmetic
  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [HEIGHT_W-1:0] self_h;
    logic [HEIGHT_W-1:0] above_h;
    logic [HEIGHT_W-1:0] below_h;
    logic [HEIGHT_W-1:0] left_h;
    logic [HEIGHT_W-1:0] right_h;
    logic                col_edge;
    logic                row_edge;
    logic                has_quad;
    logic                last;
    logic [IDX_W-1:0]    base;
    logic [SIZE_W-1:0]   grid_w;
  } job_t;

endpackage
`default_nettype wire

/* sv/hnm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_ram - generic simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module hnm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/hnm_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_queue - short job queue between front and back
// Small FIFO of vertex jobs; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module hnm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output      logic          push_ready,
  input  wire hnm_pkg::job_t push_data,
  output      logic          pop_valid,
  input  wire logic          pop_ready,
  output      hnm_pkg::job_t pop_data
);

  localparam int DEPTH = hnm_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  hnm_pkg::job_t   slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNTW'(1);
        2'b01:   count_r <= count_r - CNTW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/hnm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_front - transaction intake, classification and line store access
// Holds the size registers and raster counters, sorts each transaction into
// pixel, drain or ignored, keeps the {upper, middle} line store and forms vertex jobs.
// ----------------------------------------------------------------------------
module hnm_front #(
  parameter int MAX_WIDTH  = hnm_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = hnm_pkg::MAX_HEIGHT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [hnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hnm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_mode,
  input  wire logic [hnm_pkg::BYTE_W-1:0]       in_height_high,
  input  wire logic [hnm_pkg::BYTE_W-1:0]       in_height_low,
  output      logic                             job_valid,
  input  wire logic                             job_ready,
  output      hnm_pkg::job_t                    job
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = hnm_pkg::SIZE_W;
  localparam int HW    = hnm_pkg::HEIGHT_W;
  localparam int CMPW  = (AW > SW) ? AW : SW;
  localparam int RCMPW = (RW > SW) ? RW : SW;

  // configuration
  logic [SW-1:0] grid_width_r;
  logic [SW-1:0] grid_height_r;
  logic          flat_r;
  logic [SW-1:0] eff_w;
  logic [SW-1:0] eff_h;
  logic [SW-1:0] w_m1;
  logic [SW-1:0] h_m1;
  logic          cfg_restart;

  // raster state
  logic [AW-1:0]                in_col_r;
  logic [AW-1:0]                drain_col_r;
  logic [RW-1:0]                in_row_r;
  logic [hnm_pkg::IDX_W-1:0]    vidx_r;
  logic [HW-1:0]                prev_self_r;

  // classification
  logic              acc;
  logic              is_drain;
  logic [AW-1:0]     col_sel;
  logic [RCMPW-1:0]  row_sel;
  logic              col_first;
  logic              col_last;
  logic              row_first;
  logic              row_last;
  logic              pix_live;
  logic              drn_live;
  logic              emit;
  logic              frame_done;
  logic [HW-1:0]     cur_h;
  logic [HW-1:0]     self_h;
  logic [HW-1:0]     upper_h;

  // line store: each entry is {upper, middle} for one column
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [2*HW-1:0]   ram_wdata;
  logic [2*HW-1:0]   ram_rdata;

  // job register
  logic              s1_valid_r;
  logic              s1_last_col_r;
  hnm_pkg::job_t     s1_r;
  hnm_pkg::job_t     s1_nxt;

  always_comb begin
    if (grid_width_r < hnm_pkg::SIZE_MIN) begin
      eff_w = hnm_pkg::SIZE_MIN;
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = SW'(MAX_WIDTH);
    end else begin
      eff_w = grid_width_r;
    end
    if (grid_height_r < hnm_pkg::SIZE_MIN) begin
      eff_h = hnm_pkg::SIZE_MIN;
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = SW'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height_r;
    end
  end

  assign w_m1 = eff_w - SW'(1);
  assign h_m1 = eff_h - SW'(1);

  assign cfg_restart = cfg_we && ((cfg_index == hnm_pkg::REG_GRID_WIDTH) ||
                                  (cfg_index == hnm_pkg::REG_GRID_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= hnm_pkg::SIZE_RESET;
      grid_height_r <= hnm_pkg::SIZE_RESET;
      flat_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hnm_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        hnm_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        hnm_pkg::REG_FLAT_MODE:   flat_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !s1_valid_r || job_ready;
  assign acc      = in_valid && in_ready;

  assign is_drain  = (in_mode == hnm_pkg::MODE_DRAIN);
  assign col_sel   = is_drain ? drain_col_r : in_col_r;
  assign col_first = (col_sel == '0);
  assign col_last  = (CMPW'(col_sel) == CMPW'(w_m1));
  // pixels of row r+1 emit row r; drains emit the final row
  assign row_sel   = is_drain ? RCMPW'(h_m1) : (RCMPW'(in_row_r) - RCMPW'(1));
  assign row_first = (row_sel == '0);
  assign row_last  = (row_sel == RCMPW'(h_m1));

  assign pix_live   = !is_drain && (RCMPW'(in_row_r) < RCMPW'(eff_h));
  assign drn_live   = is_drain && (RCMPW'(in_row_r) == RCMPW'(eff_h));
  assign emit       = drn_live || (pix_live && (in_row_r != '0));
  assign frame_done = acc && drn_live && col_last;

  assign cur_h   = flat_r ? '0 : {in_height_high, in_height_low};
  assign self_h  = ram_rdata[HW-1:0];
  assign upper_h = ram_rdata[2*HW-1:HW];

  // the read data always holds the entry of the current column: each
  // transaction prefetches the next column, wrapping to column 0
  assign ram_we    = acc && pix_live;
  assign ram_re    = acc && (pix_live || drn_live);
  assign ram_raddr = col_last ? '0 : col_sel + AW'(1);
  assign ram_wdata = {self_h, cur_h};

  hnm_ram #(
    .WIDTH (2 * HW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_col_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart || frame_done) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      drain_col_r <= '0;
      vidx_r      <= '0;
    end else if (acc) begin
      if (pix_live) begin
        if (col_last) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + RW'(1);
        end else begin
          in_col_r <= in_col_r + AW'(1);
        end
      end
      if (drn_live) begin
        drain_col_r <= drain_col_r + AW'(1);
      end
      if (emit) begin
        vidx_r <= vidx_r + hnm_pkg::IDX_W'(1);
      end
    end
  end

  always_comb begin
    s1_nxt          = '0;
    s1_nxt.col      = hnm_pkg::COORD_W'(col_sel);
    s1_nxt.row      = hnm_pkg::COORD_W'(row_sel);
    s1_nxt.self_h   = self_h;
    s1_nxt.above_h  = row_first ? self_h : upper_h;
    s1_nxt.below_h  = is_drain ? self_h : cur_h;
    s1_nxt.left_h   = col_first ? self_h : prev_self_r;
    s1_nxt.right_h  = self_h;
    s1_nxt.col_edge = col_first || col_last;
    s1_nxt.row_edge = row_first || row_last;
    s1_nxt.has_quad = !col_last && !row_last;
    s1_nxt.last     = col_last && row_last;
    s1_nxt.base     = vidx_r;
    s1_nxt.grid_w   = eff_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc && emit) begin
      s1_valid_r <= 1'b1;
    end else if (job_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      s1_r          <= s1_nxt;
      s1_last_col_r <= col_last;
    end
    if (ram_re) begin
      prev_self_r <= self_h;
    end
  end

  // right neighbour comes from the prefetch read made at capture
  always_comb begin
    job         = s1_r;
    job.right_h = s1_last_col_r ? s1_r.self_h : self_h;
  end

  assign job_valid = s1_valid_r;

endmodule
`default_nettype wire

/* sv/hnm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnm_back - normal and quad index arithmetic with output register
// Takes vertex jobs from the queue, forms the central differences and the
// quad corner indices, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module hnm_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 job_valid,
  output      logic                                 job_ready,
  input  wire hnm_pkg::job_t                        job,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic [hnm_pkg::COORD_W-1:0]          out_vertex_col,
  output      logic [hnm_pkg::COORD_W-1:0]          out_vertex_row,
  output      logic [hnm_pkg::HEIGHT_W-1:0]         out_vertex_height,
  output      logic signed [hnm_pkg::NORM_W-1:0]    out_normal_x,
  output      logic signed [hnm_pkg::NORM_W-1:0]    out_normal_z,
  output      logic                                 out_has_quad,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v0,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v1,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v2,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v3,
  output      logic                                 out_last_vertex
);

  localparam int NW = hnm_pkg::NORM_W;
  localparam int IW = hnm_pkg::IDX_W;

  logic                 pop;
  logic                 out_valid_r;
  logic signed [NW-1:0] dx;
  logic signed [NW-1:0] dz;
  logic signed [NW-1:0] nx;
  logic signed [NW-1:0] nz;
  logic [IW-1:0]        v1;
  logic [IW-1:0]        v2;
  logic [IW-1:0]        v3;

  logic [hnm_pkg::COORD_W-1:0]  col_r;
  logic [hnm_pkg::COORD_W-1:0]  row_r;
  logic [hnm_pkg::HEIGHT_W-1:0] height_r;
  logic signed [NW-1:0]         nx_r;
  logic signed [NW-1:0]         nz_r;
  logic                         has_quad_r;
  logic [IW-1:0]                v0_r;
  logic [IW-1:0]                v1_r;
  logic [IW-1:0]                v2_r;
  logic [IW-1:0]                v3_r;
  logic                         last_r;

  assign job_ready = !out_valid_r || out_ready;
  assign pop       = job_valid && job_ready;

  // normal_x is left minus right, the negated horizontal difference
  assign dx = $signed(NW'(job.left_h)) - $signed(NW'(job.right_h));
  assign dz = $signed(NW'(job.below_h)) - $signed(NW'(job.above_h));
  assign nx = job.col_edge ? (dx <<< 1) : dx;
  assign nz = job.row_edge ? (dz <<< 1) : dz;

  assign v1 = job.base + IW'(1);
  assign v2 = job.base + IW'(job.grid_w);
  assign v3 = v2 + IW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (job_ready) begin
      out_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      col_r      <= job.col;
      row_r      <= job.row;
      height_r   <= job.self_h;
      nx_r       <= nx;
      nz_r       <= nz;
      has_quad_r <= job.has_quad;
      v0_r       <= job.has_quad ? job.base : '0;
      v1_r       <= job.has_quad ? v1 : '0;
      v2_r       <= job.has_quad ? v2 : '0;
      v3_r       <= job.has_quad ? v3 : '0;
      last_r     <= job.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_col    = col_r;
  assign out_vertex_row    = row_r;
  assign out_vertex_height = height_r;
  assign out_normal_x      = nx_r;
  assign out_normal_z      = nz_r;
  assign out_has_quad      = has_quad_r;
  assign out_quad_v0       = v0_r;
  assign out_quad_v1       = v1_r;
  assign out_quad_v2       = v2_r;
  assign out_quad_v3       = v3_r;
  assign out_last_vertex   = last_r;

endmodule
`default_nettype wire

/* sv/heightmap_normal_mesh_builder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_normal_mesh_builder - heightmap to mesh vertex stream
// Pixels arrive in raster order on the in_ channel (valid/ready). Each pixel
// of row r+1 produces vertex r of the same column on the out_ channel, with
// its height, central-difference normal terms and quad corner indices; after
// the last row, one drain transaction per column flushes the final row. Pixels
// of the first row, pixels past the last row and early drains give no result.
// Throughput: one transaction per cycle while in_ready is high, set by the
// single write and single read port of the {upper, middle} line store, each used once per transaction.
// A result passes through the job register, a queue slot and then the output
// register before it is presented on the out_ channel.
// A two-entry job queue sits between intake and arithmetic, so in_ready stays
// high while a result waits on out_ready, until queue and job register fill.
// Reset sets both sizes to 256, clears flat mode and restarts the frame; a
// write to a size register restarts the frame too. The line store has no
// reset; reads in the first row of a frame return data that no result uses.
// ----------------------------------------------------------------------------
module heightmap_normal_mesh_builder #(
  parameter int MAX_WIDTH  = hnm_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = hnm_pkg::MAX_HEIGHT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [hnm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [hnm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic                                 in_mode,
  input  wire logic [hnm_pkg::BYTE_W-1:0]           in_height_high,
  input  wire logic [hnm_pkg::BYTE_W-1:0]           in_height_low,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic [hnm_pkg::COORD_W-1:0]          out_vertex_col,
  output      logic [hnm_pkg::COORD_W-1:0]          out_vertex_row,
  output      logic [hnm_pkg::HEIGHT_W-1:0]         out_vertex_height,
  output      logic signed [hnm_pkg::NORM_W-1:0]    out_normal_x,
  output      logic signed [hnm_pkg::NORM_W-1:0]    out_normal_z,
  output      logic                                 out_has_quad,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v0,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v1,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v2,
  output      logic [hnm_pkg::IDX_W-1:0]            out_quad_v3,
  output      logic                                 out_last_vertex
);

  logic          fr_valid;
  logic          fr_ready;
  hnm_pkg::job_t fr_job;
  logic          bk_valid;
  logic          bk_ready;
  hnm_pkg::job_t bk_job;

  hnm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_height_high (in_height_high),
    .in_height_low  (in_height_low),
    .job_valid      (fr_valid),
    .job_ready      (fr_ready),
    .job            (fr_job)
  );

  hnm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_job)
  );

  hnm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (bk_valid),
    .job_ready         (bk_ready),
    .job               (bk_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_col    (out_vertex_col),
    .out_vertex_row    (out_vertex_row),
    .out_vertex_height (out_vertex_height),
    .out_normal_x      (out_normal_x),
    .out_normal_z      (out_normal_z),
    .out_has_quad      (out_has_quad),
    .out_quad_v0       (out_quad_v0),
    .out_quad_v1       (out_quad_v1),
    .out_quad_v2       (out_quad_v2),
    .out_quad_v3       (out_quad_v3),
    .out_last_vertex   (out_last_vertex)
  );

endmodule
`default_nettype wire
